/* sv/tnc_pkg.sv */
package tnc_pkg;

	localparam int CoordW = 32;
	localparam int EdgeW  = CoordW + 1;
	localparam int SumW   = CoordW + 2;
	localparam int ProdW  = 2 * EdgeW;
	localparam int CrossW = ProdW + 1;
	localparam int LenW   = 7;
	localparam int NormW  = 30;
	localparam int SqW    = 2 * NormW;
	localparam int RadW   = SqW + 2;
	localparam int RootW  = RadW / 2;
	localparam int QuotW  = 31;
	localparam int CfgW   = 31;
	localparam int ProdGW = CfgW + QuotW;

	localparam logic [CfgW-1:0] NormalLengthReset = 31'd6554;
	localparam logic [CfgW-1:0] PulseGainReset    = 31'd6554;
	localparam logic            PulseEnableReset  = 1'b0;
	localparam logic            BreathingReset    = 1'b1;

	// floor(x / 3) = (x * ThirdRecip) >> 33 for any x below 2^32.
	localparam logic [31:0] ThirdRecip  = 32'hAAAA_AAAB;
	// 2^31 = 3 * ThirdOfBit31 + 2.
	localparam logic [31:0] ThirdOfBit31 = 32'd715827882;

	localparam logic [QuotW-1:0] MaxPos = {QuotW{1'b1}};

	typedef enum logic [1:0] {
		REG_NORMAL_LENGTH,
		REG_PULSE_GAIN,
		REG_PULSE_ENABLE,
		REG_BREATHING_OUT
	} cfg_reg_t;

	typedef struct packed {
		logic [CfgW-1:0] normal_length;
		logic [CfgW-1:0] pulse_gain;
		logic            pulse_enable;
		logic            breathing_out;
	} cfg_t;

	// Travels with the radicand through the square root pipeline.
	typedef struct packed {
		logic [2:0][NormW-1:0]  c;
		logic [2:0]             neg;
		logic [2:0][CoordW-1:0] center;
	} side_t;

	// Travels with the quotients through the divider.
	typedef struct packed {
		logic [2:0]             neg;
		logic [2:0][CoordW-1:0] center;
	} tail_t;

endpackage

/* sv/tnc_front.sv */
module tnc_front
	import tnc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [8:0][CoordW-1:0]   in_coord,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [RadW-1:0]          out_rad,
	output side_t                    out_side
);

	localparam int NumStages = 8;

	logic [NumStages:1] adv;
	logic [NumStages:1] vld_q;

	logic signed [EdgeW-1:0]  e1_s1 [3];
	logic signed [EdgeW-1:0]  e2_s1 [3];
	logic signed [SumW-1:0]   sum_s1 [3];
	logic signed [ProdW-1:0]  p_s2 [6];
	logic [31:0]              y_s2 [3];
	logic [1:0]               a_s2 [3];
	logic [2:0]               cneg_s2;
	logic signed [CrossW-1:0] n_s3 [3];
	logic [63:0]              prod_s3 [3];
	logic [1:0]               a_s3 [3];
	logic [2:0]               cneg_s3;
	logic [CrossW-1:0]        m_s4 [3];
	logic [2:0]               neg_s4;
	logic [CoordW-1:0]        center_s4 [3];
	logic [CrossW-1:0]        m_s5 [3];
	logic [LenW-1:0]          blen_s5;
	logic [2:0]               neg_s5;
	logic [CoordW-1:0]        center_s5 [3];
	logic [NormW-1:0]         c_s6 [3];
	logic [2:0]               neg_s6;
	logic [CoordW-1:0]        center_s6 [3];
	logic [SqW-1:0]           sq_s7 [3];
	logic [NormW-1:0]         c_s7 [3];
	logic [2:0]               neg_s7;
	logic [CoordW-1:0]        center_s7 [3];
	logic [RadW-1:0]          rad_s8;
	logic [NormW-1:0]         c_s8 [3];
	logic [2:0]               neg_s8;
	logic [CoordW-1:0]        center_s8 [3];

	logic [SumW-1:0]   cmag [3];
	logic [SumW-1:0]   cx [3];
	logic [31:0]       cq [3];
	logic [CrossW-1:0] orv;
	logic [LenW-1:0]   blen;

	always_comb begin
		adv[NumStages] = !vld_q[NumStages] || out_ready;
		for (int k = NumStages - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_q[NumStages];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NumStages; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cmag[i] = sum_s1[i][SumW-1] ? SumW'(-sum_s1[i]) : SumW'(sum_s1[i]);
			cx[i]   = cmag[i] + SumW'(1);
			cq[i]   = 32'(prod_s3[i][63:33]) + 32'(a_s3[i]) * ThirdOfBit31;
		end
		orv = m_s4[0] | m_s4[1] | m_s4[2];
		blen = '0;
		for (int b = 0; b < CrossW; b++) begin
			if (orv[b]) begin
				blen = LenW'(b + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i]  <= EdgeW'(signed'(in_coord[3+i])) - EdgeW'(signed'(in_coord[i]));
				e2_s1[i]  <= EdgeW'(signed'(in_coord[6+i])) - EdgeW'(signed'(in_coord[i]));
				sum_s1[i] <= SumW'(signed'(in_coord[i])) + SumW'(signed'(in_coord[3+i]))
					+ SumW'(signed'(in_coord[6+i]));
			end
		end
		if (adv[2]) begin
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
			for (int i = 0; i < 3; i++) begin
				a_s2[i]    <= cx[i][32:31];
				y_s2[i]    <= 32'({cx[i][32:31], 1'b0}) + 32'(cx[i][30:0]);
				cneg_s2[i] <= sum_s1[i][SumW-1];
			end
		end
		if (adv[3]) begin
			n_s3[0] <= CrossW'(p_s2[0]) - CrossW'(p_s2[1]);
			n_s3[1] <= CrossW'(p_s2[2]) - CrossW'(p_s2[3]);
			n_s3[2] <= CrossW'(p_s2[4]) - CrossW'(p_s2[5]);
			for (int i = 0; i < 3; i++) begin
				prod_s3[i] <= 64'(y_s2[i]) * 64'(ThirdRecip);
				a_s3[i]    <= a_s2[i];
			end
			cneg_s3 <= cneg_s2;
		end
		if (adv[4]) begin
			for (int i = 0; i < 3; i++) begin
				m_s4[i]      <= n_s3[i][CrossW-1] ? CrossW'(-n_s3[i]) : CrossW'(n_s3[i]);
				neg_s4[i]    <= n_s3[i][CrossW-1];
				center_s4[i] <= cneg_s3[i] ? -cq[i] : cq[i];
			end
		end
		if (adv[5]) begin
			m_s5      <= m_s4;
			blen_s5   <= blen;
			neg_s5    <= neg_s4;
			center_s5 <= center_s4;
		end
		if (adv[6]) begin
			for (int i = 0; i < 3; i++) begin
				if (blen_s5 > LenW'(NormW)) begin
					c_s6[i] <= NormW'(m_s5[i] >> (blen_s5 - LenW'(NormW)));
				end else begin
					c_s6[i] <= NormW'(m_s5[i] << (LenW'(NormW) - blen_s5));
				end
			end
			neg_s6    <= neg_s5;
			center_s6 <= center_s5;
		end
		if (adv[7]) begin
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= SqW'(c_s6[i]) * SqW'(c_s6[i]);
			end
			c_s7      <= c_s6;
			neg_s7    <= neg_s6;
			center_s7 <= center_s6;
		end
		if (adv[8]) begin
			rad_s8    <= RadW'(sq_s7[0]) + RadW'(sq_s7[1]) + RadW'(sq_s7[2]);
			c_s8      <= c_s7;
			neg_s8    <= neg_s7;
			center_s8 <= center_s7;
		end
	end

	always_comb begin
		out_rad = rad_s8;
		for (int i = 0; i < 3; i++) begin
			out_side.c[i]      = c_s8[i];
			out_side.center[i] = center_s8[i];
		end
		out_side.neg = neg_s8;
	end

endmodule

/* sv/tnc_isqrt.sv */
module tnc_isqrt
	import tnc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [RadW-1:0]  in_rad,
	input  side_t            in_side,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [RootW-1:0] out_root,
	output side_t            out_side
);

	// One result bit is settled in each stage.
	logic [RootW-1:0] adv;
	logic [RootW-1:0] vld_s;
	logic [RadW-1:0]  rem_s [RootW];
	logic [RadW-1:0]  res_s [RootW];
	side_t            side_s [RootW];

	for (genvar k = 0; k < RootW; k++) begin : g_stage
		localparam logic [RadW-1:0] Bit = RadW'(1) << (2 * (RootW - 1 - k));
		logic [RadW-1:0] rem_in;
		logic [RadW-1:0] res_in;
		side_t           side_in;
		logic            vld_in;
		logic [RadW-1:0] trial;
		logic            take;

		if (k == 0) begin : g_first
			assign rem_in  = in_rad;
			assign res_in  = '0;
			assign side_in = in_side;
			assign vld_in  = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign res_in  = res_s[k-1];
			assign side_in = side_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		if (k == RootW - 1) begin : g_last
			assign adv[k] = !vld_s[k] || out_ready;
		end else begin : g_mid
			assign adv[k] = !vld_s[k] || adv[k+1];
		end

		assign trial = res_in + Bit;
		assign take  = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rem_s[k]  <= take ? rem_in - trial : rem_in;
				res_s[k]  <= take ? (res_in >> 1) + Bit : res_in >> 1;
				side_s[k] <= side_in;
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_s[RootW-1];
	assign out_root  = res_s[RootW-1][RootW-1:0];
	assign out_side  = side_s[RootW-1];

endmodule

/* sv/tnc_divider.sv */
module tnc_divider
	import tnc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [RootW-1:0]       in_root,
	input  side_t                  in_side,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0][QuotW-1:0]  out_quot,
	output tail_t                  out_tail
);

	localparam int NumStages = QuotW + 1;

	// Stage 0 forms the rounded numerators, each later stage settles one quotient bit.
	logic [NumStages-1:0]  adv;
	logic [NumStages-1:0]  vld_s;
	logic [RadW-1:0]       rem_s [NumStages][3];
	logic [QuotW-1:0]      quot_s [NumStages][3];
	logic [RootW-1:0]      div_s [NumStages];
	tail_t                 tail_s [NumStages];

	for (genvar k = 0; k < NumStages; k++) begin : g_stage
		if (k == NumStages - 1) begin : g_last
			assign adv[k] = !vld_s[k] || out_ready;
		end else begin : g_mid
			assign adv[k] = !vld_s[k] || adv[k+1];
		end

		if (k == 0) begin : g_num
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (adv[k]) begin
					vld_s[k] <= in_valid;
				end
			end

			always_ff @(posedge clk) begin
				if (adv[k]) begin
					for (int i = 0; i < 3; i++) begin
						rem_s[k][i]  <= RadW'(cfg.normal_length) * RadW'(in_side.c[i])
							+ RadW'(in_root >> 1);
						quot_s[k][i] <= '0;
					end
					// A degenerate triangle has a zero numerator; a unit divisor keeps it zero.
					div_s[k]         <= (in_root == '0) ? RootW'(1) : in_root;
					tail_s[k].neg    <= in_side.neg;
					tail_s[k].center <= in_side.center;
				end
			end
		end else begin : g_bit
			localparam int Pos = QuotW - k;
			logic [RadW-1:0] shifted;
			logic [2:0]      take;

			assign shifted = RadW'(div_s[k-1]) << Pos;
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					take[i] = rem_s[k-1][i] >= shifted;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (adv[k]) begin
					for (int i = 0; i < 3; i++) begin
						rem_s[k][i]  <= take[i] ? rem_s[k-1][i] - shifted : rem_s[k-1][i];
						quot_s[k][i] <= quot_s[k-1][i] | (QuotW'(take[i]) << Pos);
					end
					div_s[k]  <= div_s[k-1];
					tail_s[k] <= tail_s[k-1];
				end
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_s[NumStages-1];
	assign out_tail  = tail_s[NumStages-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			out_quot[i] = quot_s[NumStages-1][i];
		end
	end

endmodule

/* sv/tnc_back.sv */
module tnc_back
	import tnc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [2:0][QuotW-1:0]  in_quot,
	input  tail_t                  in_tail,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [8:0][CoordW-1:0] out_word
);

	localparam int RoundW = ProdGW - 16;

	logic adv_b1;
	logic adv_b2;
	logic vld_s1;
	logic vld_s2;

	logic [ProdGW-1:0]      prod_s1 [3];
	logic [QuotW-1:0]       nm_s1 [3];
	tail_t                  tail_s1;
	logic [8:0][CoordW-1:0] word_s2;

	logic [RoundW-1:0] rnd [3];
	logic [QuotW-1:0]  sm [3];
	logic [CoordW-1:0] nrm [3];
	logic [CoordW-1:0] shf [3];
	logic              sneg [3];

	assign adv_b2    = !vld_s2 || out_ready;
	assign adv_b1    = !vld_s1 || adv_b2;
	assign in_ready  = adv_b1;
	assign out_valid = vld_s2;
	assign out_word  = word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_b1) begin
				vld_s1 <= in_valid;
			end
			if (adv_b2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i]  = RoundW'((prod_s1[i] + ProdGW'(32'h8000)) >> 16);
			sm[i]   = (rnd[i] > RoundW'(MaxPos)) ? MaxPos : rnd[i][QuotW-1:0];
			sneg[i] = cfg.breathing_out ? tail_s1.neg[i] : !tail_s1.neg[i];
			nrm[i]  = tail_s1.neg[i] ? -CoordW'(nm_s1[i]) : CoordW'(nm_s1[i]);
			if (!cfg.pulse_enable) begin
				shf[i] = '0;
			end else begin
				shf[i] = sneg[i] ? -CoordW'(sm[i]) : CoordW'(sm[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_b1) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= ProdGW'(cfg.pulse_gain) * ProdGW'(in_quot[i]);
				nm_s1[i]   <= in_quot[i];
			end
			tail_s1 <= in_tail;
		end
		if (adv_b2) begin
			for (int i = 0; i < 3; i++) begin
				word_s2[i]   <= nrm[i];
				word_s2[3+i] <= tail_s1.center[i];
				word_s2[6+i] <= shf[i];
			end
		end
	end

endmodule

/* sv/triangle_normal_centroid_unit.sv */
// Triangle normal and centroid unit. Each input word is one triangle (three vertices in
// signed Q16.16); each output word carries the face normal scaled to normal_length, the
// centroid rounded to nearest, and the pulse displacement along the normal. The unit takes
// one triangle in every clock while not stalled and gives one result per triangle, in order,
// after eight front stages (edges, cross products, magnitude, bit length, normalising shift,
// squares and their sum), 31 integer square root stages with one root bit each, one stage
// forming rounded numerators, 31 divider stages with one quotient bit each, and two stages
// for the displacement product and the output register. A stage holds its word while the next
// is stalled, so output back-pressure stalls the chain without loss, and bubbles are squeezed
// out. A degenerate triangle gives a zero normal and displacement. Registers must be written
// over the APB port only while no triangle is in flight; the unit does not enforce it.
module triangle_normal_centroid_unit
	import tnc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// Input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// from bit 0 up: first_x, first_y, first_z, second_x, second_y, second_z,
	// third_x, third_y, third_z, 32 bits each
	input  logic [287:0] s_tdata,
	// Output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// from bit 0 up: normal_x, normal_y, normal_z, center_x, center_y, center_z,
	// shift_x, shift_y, shift_z, 32 bits each
	output logic [287:0] m_tdata
);

	logic [CfgW-1:0] normal_length_q;
	logic [CfgW-1:0] pulse_gain_q;
	logic            pulse_enable_q;
	logic            breathing_out_q;
	cfg_t            cfg;
	cfg_reg_t        reg_sel;

	logic                   f_valid;
	logic                   f_ready;
	logic [RadW-1:0]        f_rad;
	side_t                  f_side;
	logic                   r_valid;
	logic                   r_ready;
	logic [RootW-1:0]       r_root;
	side_t                  r_side;
	logic                   d_valid;
	logic                   d_ready;
	logic [2:0][QuotW-1:0]  d_quot;
	tail_t                  d_tail;
	logic [8:0][CoordW-1:0] in_coord;
	logic [8:0][CoordW-1:0] out_word;

	// The register file. Each register sits at four times its index; the write lands on
	// the access cycle, and reads are answered straight from the registers.
	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_length_q <= NormalLengthReset;
			pulse_gain_q    <= PulseGainReset;
			pulse_enable_q  <= PulseEnableReset;
			breathing_out_q <= BreathingReset;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_NORMAL_LENGTH: normal_length_q <= pwdata[CfgW-1:0];
				REG_PULSE_GAIN:    pulse_gain_q    <= pwdata[CfgW-1:0];
				REG_PULSE_ENABLE:  pulse_enable_q  <= pwdata[0];
				REG_BREATHING_OUT: breathing_out_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_NORMAL_LENGTH: prdata = 32'(normal_length_q);
			REG_PULSE_GAIN:    prdata = 32'(pulse_gain_q);
			REG_PULSE_ENABLE:  prdata = 32'(pulse_enable_q);
			REG_BREATHING_OUT: prdata = 32'(breathing_out_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.normal_length = normal_length_q;
	assign cfg.pulse_gain    = pulse_gain_q;
	assign cfg.pulse_enable  = pulse_enable_q;
	assign cfg.breathing_out = breathing_out_q;

	assign in_coord = s_tdata;
	assign m_tdata  = out_word;

	// Geometry front end: cross product, normalisation to 30 bits and the sum of squares,
	// with the centroid worked out alongside.
	tnc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_coord  (in_coord),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_rad   (f_rad),
		.out_side  (f_side)
	);

	// Length of the normalised cross product.
	tnc_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_rad    (f_rad),
		.in_side   (f_side),
		.out_valid (r_valid),
		.out_ready (r_ready),
		.out_root  (r_root),
		.out_side  (r_side)
	);

	// Scaling of each component to the configured length, rounded to nearest.
	tnc_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (r_valid),
		.in_ready  (r_ready),
		.in_root   (r_root),
		.in_side   (r_side),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_quot  (d_quot),
		.out_tail  (d_tail)
	);

	// Displacement, signs and the output register.
	tnc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.in_quot   (d_quot),
		.in_tail   (d_tail),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (out_word)
	);

endmodule
